>>> sv/qat_pkg.sv
`timescale 1ns / 1ps

package qat_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int RES_MAX = 3;

  localparam logic [7:0] CAP_RESET    = 8'd16;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } src_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_out;
    logic [7:0] argument_index;
    logic [7:0] argument_count;
    logic       last;
  } dst_item_t;

  // one result, as the front queues it
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [7:0] idx;
    logic [7:0] cnt;
  } res_t;

  // all results of one transaction; num is 1 to RES_MAX
  typedef struct packed {
    logic [1:0]          num;
    res_t [RES_MAX-1:0]  res;
  } entry_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] ch, logic [7:0] idx,
                                  logic [7:0] cnt);
    res_t r;
    r.kind = k;
    r.ch   = ch;
    r.idx  = idx;
    r.cnt  = cnt;
    return r;
  endfunction

endpackage

>>> sv/qat_front.sv
`timescale 1ns / 1ps

module qat_front import qat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       src_valid,
  output logic       src_stall,
  input  src_item_t  src_item,
  input  logic       q_full,
  output logic       push,
  output entry_t     entry
);

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } qmode_t;

  logic [7:0] capacity;
  qmode_t     qmode, qmode_next;
  logic       in_arg, in_arg_next;
  logic       esc, esc_next;
  logic [7:0] seen, seen_next;
  logic       failed, failed_next;

  logic       fire;
  logic [7:0] c;
  logic       blank;
  logic [7:0] close_q;
  logic [7:0] idx_now;
  logic [7:0] idx_new;
  logic [1:0] slot;

  assign src_stall = q_full;
  assign fire      = src_valid && !q_full;
  assign c         = src_item.char_in;
  assign blank     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign close_q   = (qmode == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
  assign idx_now   = seen - 8'd1;
  assign idx_new   = seen_next - 8'd1;

  always_comb begin
    qmode_next  = qmode;
    in_arg_next = in_arg;
    esc_next    = esc;
    seen_next   = seen;
    failed_next = failed;
    entry       = '0;
    slot        = 2'd0;

    if (src_item.end_of_line) begin
      if (failed) begin
        entry.res[slot] = mk_res(KIND_REJECT, 8'd0, 8'd0, 8'd0);
        slot = slot + 2'd1;
      end else begin
        if (esc) begin
          entry.res[slot] = mk_res(KIND_BYTE, CH_BACKSLASH, idx_now, 8'd0);
          slot = slot + 2'd1;
        end
        if (qmode != Q_NONE || capacity == 8'd0) begin
          entry.res[slot] = mk_res(KIND_REJECT, 8'd0, 8'd0, 8'd0);
          slot = slot + 2'd1;
        end else begin
          if (in_arg) begin
            entry.res[slot] = mk_res(KIND_END, 8'd0, idx_now, 8'd0);
            slot = slot + 2'd1;
          end
          entry.res[slot] = mk_res(KIND_ACCEPT, 8'd0, 8'd0, seen);
          slot = slot + 2'd1;
        end
      end
      qmode_next  = Q_NONE;
      in_arg_next = 1'b0;
      esc_next    = 1'b0;
      seen_next   = 8'd0;
      failed_next = 1'b0;
    end else if (!failed) begin
      if (esc) begin
        esc_next = 1'b0;
        entry.res[slot] = mk_res(KIND_BYTE, c, idx_now, 8'd0);
        slot = slot + 2'd1;
      end else if (qmode != Q_NONE) begin
        if (c == close_q) begin
          qmode_next = Q_NONE;
        end else if (c == CH_BACKSLASH) begin
          esc_next = 1'b1;
        end else begin
          entry.res[slot] = mk_res(KIND_BYTE, c, idx_now, 8'd0);
          slot = slot + 2'd1;
        end
      end else if (!in_arg && blank) begin
        // separator
      end else if (!in_arg && seen >= capacity) begin
        failed_next = 1'b1;
      end else begin
        if (!in_arg) begin
          seen_next   = seen + 8'd1;
          in_arg_next = 1'b1;
        end
        if (c == CH_SQUOTE) begin
          qmode_next = Q_SINGLE;
        end else if (c == CH_DQUOTE) begin
          qmode_next = Q_DOUBLE;
        end else if (blank) begin
          entry.res[slot] = mk_res(KIND_END, 8'd0, idx_new, 8'd0);
          slot = slot + 2'd1;
          in_arg_next = 1'b0;
        end else if (c == CH_BACKSLASH) begin
          esc_next = 1'b1;
        end else begin
          entry.res[slot] = mk_res(KIND_BYTE, c, idx_new, 8'd0);
          slot = slot + 2'd1;
        end
      end
    end
    entry.num = slot;
  end

  assign push = fire && (slot != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      qmode    <= Q_NONE;
      in_arg   <= 1'b0;
      esc      <= 1'b0;
      seen     <= 8'd0;
      failed   <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (fire) begin
        qmode  <= qmode_next;
        in_arg <= in_arg_next;
        esc    <= esc_next;
        seen   <= seen_next;
        failed <= failed_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    fire && src_item.end_of_line |=> seen == 8'd0 && !in_arg && !esc && !failed)
    else $error("line state not cleared after end of line");

  a_failed_silent: assert property (@(posedge clk) disable iff (rst)
    fire && failed && !src_item.end_of_line |-> !push)
    else $error("result queued on a rejected line");

  a_eol_pushes: assert property (@(posedge clk) disable iff (rst)
    fire && src_item.end_of_line |-> push && entry.res[entry.num - 2'd1].kind != KIND_BYTE)
    else $error("end of line without accept or reject");
`endif

endmodule

>>> sv/qat_queue.sv
`timescale 1ns / 1ps

module qat_queue import qat_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    not_empty |-> head.num != 2'd0)
    else $error("queued transaction carries no result");
`endif

endmodule

>>> sv/qat_back.sv
`timescale 1ns / 1ps

module qat_back import qat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  entry_t    head,
  output logic      pop,
  output logic      dst_valid,
  input  logic      dst_stall,
  output dst_item_t dst_item
);

  logic [1:0] sub;
  logic       load;
  logic       at_last;
  res_t       cur;

  assign load    = q_valid && (!dst_valid || !dst_stall);
  assign at_last = (sub == head.num - 2'd1);
  assign pop     = load && at_last;
  assign cur     = head.res[sub];

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      sub       <= 2'd0;
    end else begin
      if (load) begin
        dst_valid <= 1'b1;
        sub       <= at_last ? 2'd0 : sub + 2'd1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dst_item.kind           <= cur.kind;
      dst_item.char_out       <= cur.ch;
      dst_item.argument_index <= cur.idx;
      dst_item.argument_count <= cur.cnt;
      dst_item.last           <= at_last;
    end
  end

endmodule

>>> sv/quoted_argument_tokenizer_core.sv
`timescale 1ns / 1ps

// channel  | valid      | stall      | payload
// ---------+------------+------------+----------------------------------
// source   | src_valid  | src_stall  | src_item (char_in, end_of_line)
// result   | dst_valid  | dst_stall  | dst_item (kind ... last)
// config   | cfg_write  | -          | cfg_data (argument_capacity)
//
// One byte is taken per cycle while the 4-entry transaction queue has room.
// Results leave one per cycle from the output register while dst_stall is low.
// A transaction with k results (k up to 3, only at end of line) leaves the
// queue with its last result; each result is held in the queue, then the output register.
// rst is synchronous; it empties the queue and sets capacity to 16.
// dst_stall backs up into the queue and then into src_stall.

module quoted_argument_tokenizer_core import qat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       src_valid,
  output logic       src_stall,
  input  src_item_t  src_item,
  output logic       dst_valid,
  input  logic       dst_stall,
  output dst_item_t  dst_item
);

  logic   push;
  entry_t wr_entry;
  logic   q_full;
  logic   pop;
  logic   q_valid;
  entry_t head;

  qat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .q_full    (q_full),
    .push      (push),
    .entry     (wr_entry)
  );

  qat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  qat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

endmodule
